/* hdl/wkb_pkg.sv */
// Package with parse phase codes, status codes and bound constants for the WKB parser.
package wkb_pkg;

  localparam int unsigned DIMS_DEF = 2;
  localparam int unsigned DIMS_MAX = 4;

  typedef enum logic [3:0] {
    PH_BO     = 4'd0,
    PH_TYPE   = 4'd1,
    PH_NITEMS = 4'd2,
    PH_ITEMHD = 4'd3,
    PH_NRINGS = 4'd4,
    PH_NPTS   = 4'd5,
    PH_COORD  = 4'd6,
    PH_NCOLL  = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_BAD_TYPE  = 2'd2,
    ST_NESTED    = 2'd3
  } status_t;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_POINT = 3'd1;
  localparam logic [2:0] KIND_LINE  = 3'd2;
  localparam logic [2:0] KIND_POLY  = 3'd3;
  localparam logic [2:0] KIND_MPT   = 3'd4;
  localparam logic [2:0] KIND_COLL  = 3'd7;

  localparam logic [63:0] BIG_POS = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BIG_NEG = 64'hFFEF_FFFF_FFFF_FFFF;

  // Ordered IEEE less-than on raw bits; false whenever either side is NaN.
  function automatic logic dbl_lt(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    if (a_nan || b_nan || both_zero) begin
      dbl_lt = 1'b0;
    end else if (a[63] != b[63]) begin
      dbl_lt = a[63];
    end else if (a[63]) begin
      dbl_lt = a[62:0] > b[62:0];
    end else begin
      dbl_lt = a[62:0] < b[62:0];
    end
  endfunction

  // Result of one parsed byte, handed from the parser to the bounds unit.
  typedef struct packed {
    logic        coord_valid;
    logic [1:0]  axis;
    logic [63:0] coord;
    logic        last;
    logic        finished;
    logic [1:0]  fault;
  } parse_ev_t;

endpackage

/* hdl/wkb_parser.sv */
// Byte-level WKB parse state machine; emits completed coordinates and end-of-blob events.
module wkb_parser #(
  parameter int unsigned DIMS = wkb_pkg::DIMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output wkb_pkg::parse_ev_t ev
);
  import wkb_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  bif_r, bif_nxt;
  logic [55:0] shift_r, shift_nxt;
  logic [2:0]  outer_r, outer_nxt;
  logic [2:0]  member_r, member_nxt;
  logic [31:0] coll_r, coll_nxt;
  logic [31:0] items_r, items_nxt;
  logic [31:0] rings_r, rings_nxt;
  logic [31:0] pts_r, pts_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  fault_r, fault_nxt;

  logic [63:0] full;
  logic [31:0] n;
  logic        complete;
  logic [2:0]  ek;
  logic [1:0]  a;

  // Completion chain: point/ring/element/geometry done, each level falls through.
  logic do_ring, do_elem, do_geom;

  always_comb begin
    phase_nxt  = phase_r;
    bif_nxt    = bif_r;
    shift_nxt  = shift_r;
    outer_nxt  = outer_r;
    member_nxt = member_r;
    coll_nxt   = coll_r;
    items_nxt  = items_r;
    rings_nxt  = rings_r;
    pts_nxt    = pts_r;
    axis_nxt   = axis_r;
    fin_nxt    = fin_r;
    fault_nxt  = fault_r;
    do_ring    = 1'b0;
    do_elem    = 1'b0;
    do_geom    = 1'b0;
    ev         = '0;
    full = {8'd0, shift_r};
    case (bif_r)
      3'd0: full[7:0] = data_byte;
      3'd1: full[15:8] = data_byte;
      3'd2: full[23:16] = data_byte;
      3'd3: full[31:24] = data_byte;
      3'd4: full[39:32] = data_byte;
      3'd5: full[47:40] = data_byte;
      3'd6: full[55:48] = data_byte;
      default: full[63:56] = data_byte;
    endcase
    n = full[31:0];
    complete = (phase_r == PH_COORD) ? (bif_r == 3'd7) : (bif_r == 3'd3);
    ek = (member_r > 3'd3) ? member_r - 3'd3 : member_r;
    a = (32'(axis_r) < DIMS) ? axis_r : 2'd0;

    if (take) begin
      case (phase_r)
        PH_BO: begin
          phase_nxt = PH_TYPE;
          bif_nxt = 3'd0;
          shift_nxt = '0;
        end
        PH_ITEMHD: begin
          if (bif_r >= 3'd4) begin
            bif_nxt = 3'd0;
            case (member_r - 3'd3)
              KIND_POINT: begin
                pts_nxt = 32'd1;
                axis_nxt = 2'd0;
                phase_nxt = PH_COORD;
              end
              KIND_LINE: phase_nxt = PH_NPTS;
              default:   phase_nxt = PH_NRINGS;
            endcase
          end else begin
            bif_nxt = bif_r + 3'd1;
          end
        end
        PH_DONE: ;
        default: begin
          if (!complete) begin
            shift_nxt = full[55:0];
            bif_nxt = bif_r + 3'd1;
          end else begin
            shift_nxt = '0;
            bif_nxt = 3'd0;
            case (phase_r)
              PH_TYPE: begin
                if (outer_r == KIND_NONE && (n < 32'd1 || n > 32'd7)) begin
                  fault_nxt = ST_BAD_TYPE;
                  phase_nxt = PH_DONE;
                end else if (outer_r == KIND_NONE && n == 32'd7) begin
                  outer_nxt = KIND_COLL;
                  phase_nxt = PH_NCOLL;
                end else if (outer_r != KIND_NONE && n == 32'd7) begin
                  fault_nxt = ST_NESTED;
                  phase_nxt = PH_DONE;
                end else if (outer_r != KIND_NONE && (n < 32'd1 || n > 32'd6)) begin
                  fault_nxt = ST_BAD_TYPE;
                  phase_nxt = PH_DONE;
                end else begin
                  if (outer_r == KIND_NONE) outer_nxt = n[2:0];
                  member_nxt = n[2:0];
                  case (n[2:0])
                    KIND_POINT: begin
                      pts_nxt = 32'd1;
                      axis_nxt = 2'd0;
                      phase_nxt = PH_COORD;
                    end
                    KIND_LINE: phase_nxt = PH_NPTS;
                    KIND_POLY: phase_nxt = PH_NRINGS;
                    default:   phase_nxt = PH_NITEMS;
                  endcase
                end
              end
              PH_NITEMS: begin
                items_nxt = n;
                if (n == 32'd0) do_geom = 1'b1;
                else phase_nxt = PH_ITEMHD;
              end
              PH_NRINGS: begin
                rings_nxt = n;
                if (n == 32'd0) do_elem = 1'b1;
                else phase_nxt = PH_NPTS;
              end
              PH_NPTS: begin
                pts_nxt = n;
                axis_nxt = 2'd0;
                if (n == 32'd0) do_ring = 1'b1;
                else phase_nxt = PH_COORD;
              end
              PH_COORD: begin
                ev.coord_valid = 1'b1;
                ev.axis = a;
                ev.coord = full;
                if (32'(a) + 32'd1 >= DIMS) begin
                  axis_nxt = 2'd0;
                  pts_nxt = pts_r - 32'd1;
                  if (pts_r == 32'd1) do_ring = 1'b1;
                end else begin
                  axis_nxt = a + 2'd1;
                end
              end
              PH_NCOLL: begin
                coll_nxt = n;
                if (n == 32'd0) begin
                  fin_nxt = 1'b1;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_BO;
                end
              end
              default: ;
            endcase
          end
        end
      endcase

      if (do_ring) begin
        if (ek == KIND_POLY) begin
          rings_nxt = rings_r - 32'd1;
          if (rings_r != 32'd1) phase_nxt = PH_NPTS;
          else do_elem = 1'b1;
        end else begin
          do_elem = 1'b1;
        end
      end
      if (do_elem) begin
        if (member_r >= KIND_MPT) begin
          items_nxt = items_nxt - 32'd1;
          if (items_nxt != 32'd0) phase_nxt = PH_ITEMHD;
          else do_geom = 1'b1;
        end else begin
          do_geom = 1'b1;
        end
      end
      if (do_geom) begin
        if (outer_r == KIND_COLL) begin
          coll_nxt = coll_r - 32'd1;
          if (coll_r != 32'd1) phase_nxt = PH_BO;
          else begin
            fin_nxt = 1'b1;
            phase_nxt = PH_DONE;
          end
        end else begin
          fin_nxt = 1'b1;
          phase_nxt = PH_DONE;
        end
      end

      ev.last = last_byte;
      ev.finished = fin_nxt;
      ev.fault = fault_nxt;
      if (last_byte) begin
        phase_nxt  = PH_BO;
        bif_nxt    = 3'd0;
        shift_nxt  = '0;
        outer_nxt  = KIND_NONE;
        member_nxt = KIND_NONE;
        coll_nxt   = '0;
        items_nxt  = '0;
        rings_nxt  = '0;
        pts_nxt    = '0;
        axis_nxt   = '0;
        fin_nxt    = 1'b0;
        fault_nxt  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BO;
      bif_r    <= '0;
      shift_r  <= '0;
      outer_r  <= KIND_NONE;
      member_r <= KIND_NONE;
      coll_r   <= '0;
      items_r  <= '0;
      rings_r  <= '0;
      pts_r    <= '0;
      axis_r   <= '0;
      fin_r    <= 1'b0;
      fault_r  <= ST_OK;
    end else begin
      phase_r  <= phase_nxt;
      bif_r    <= bif_nxt;
      shift_r  <= shift_nxt;
      outer_r  <= outer_nxt;
      member_r <= member_nxt;
      coll_r   <= coll_nxt;
      items_r  <= items_nxt;
      rings_r  <= rings_nxt;
      pts_r    <= pts_nxt;
      axis_r   <= axis_nxt;
      fin_r    <= fin_nxt;
      fault_r  <= fault_nxt;
    end
  end

endmodule

/* hdl/wkb_bounds.sv */
// Per-axis min/max registers, one ordered compare pair per coordinate, and result snapshot.
module wkb_bounds #(
  parameter int unsigned DIMS = wkb_pkg::DIMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wkb_pkg::parse_ev_t ev,
  input  logic               snap_take,
  output logic [63:0]        snap_lo [DIMS],
  output logic [63:0]        snap_hi [DIMS],
  output logic [1:0]         snap_status
);
  import wkb_pkg::*;

  logic [63:0] min_r [DIMS];
  logic [63:0] max_r [DIMS];
  logic [63:0] min_nxt [DIMS];
  logic [63:0] max_nxt [DIMS];

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      min_nxt[i] = min_r[i];
      max_nxt[i] = max_r[i];
      if (ev.coord_valid && 32'(ev.axis) == i) begin
        if (dbl_lt(ev.coord, min_r[i])) min_nxt[i] = ev.coord;
        if (dbl_lt(max_r[i], ev.coord)) max_nxt[i] = ev.coord;
      end
      snap_lo[i] = min_nxt[i];
      snap_hi[i] = max_nxt[i];
    end
    if (ev.fault != ST_OK) snap_status = ev.fault;
    else if (ev.finished) snap_status = ST_OK;
    else snap_status = ST_TRUNCATED;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIMS; i++) begin
      if (!rst_n || (snap_take && ev.last)) begin
        min_r[i] <= BIG_POS;
        max_r[i] <= BIG_NEG;
      end else begin
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
      end
    end
  end

endmodule

/* hdl/wkb_bounding_box_parser.sv */
// Top level of the WKB bounding box parser: input register, parser, bounds and result queue.
//
// Usage: the input channel carries one byte of a WKB geometry (SRID already
// removed) per beat, with in_last_byte marking the final byte of a blob.
// The block parses points, linestrings, polygons, the multi kinds and one
// level of collection, reading counts and doubles little-endian.
// When the last byte is parsed, DIMS result beats leave on the output
// channel, one per axis in order 0..DIMS-1, carrying raw double bits of the
// axis minimum and maximum and a status; out_last_result marks the last.
// Throughput: one input beat per cycle. An input beat is registered, then
// parsed in the next cycle; a last byte loads a result buffer that then
// drains one beat per cycle unless out_stall is high, while the next blob
// keeps streaming in. Only a last byte waits, until the previous blob's
// final result beat leaves. A last byte passes the input register, then
// loads the result buffer that presents the first result beat.
// Reset (rst_n low, synchronous) returns the parser to the start of a blob,
// sets the bounds to the largest finite double and its negation and empties
// the result buffer. While the receiver stalls, held results stay put and
// the input stalls only once the buffer is full and a last byte waits.
module wkb_bounding_box_parser #(
  parameter int unsigned DIMS = wkb_pkg::DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_dimension,
  output logic [63:0] out_low_bound,
  output logic [63:0] out_high_bound,
  output logic [1:0]  out_status,
  output logic        out_last_result
);
  import wkb_pkg::*;

  localparam int unsigned AW = (DIMS > 1) ? $clog2(DIMS) : 1;

  // Input register.
  logic       iv_r, iv_nxt;
  logic [7:0] ib_r;
  logic       il_r;

  // Result buffer holding one blob's worth of axis results.
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [63:0]   rlo_r [DIMS];
  logic [63:0]   rhi_r [DIMS];
  logic [1:0]    rst_r;

  logic        take;
  parse_ev_t   ev;
  logic [63:0] snap_lo [DIMS];
  logic [63:0] snap_hi [DIMS];
  logic [1:0]  snap_status;
  logic        drain_last;

  // The registered byte is parsed when it is not a last byte, or when the
  // result buffer is free (or frees up this cycle).
  assign drain_last = rv_r && !out_stall && (32'(ridx_r) == DIMS - 1);
  assign take = iv_r && (!il_r || !rv_r || drain_last);
  assign in_stall = iv_r && !take;

  always_comb begin
    iv_nxt = iv_r;
    if (take) iv_nxt = 1'b0;
    if (in_valid && !in_stall) iv_nxt = 1'b1;
    rv_nxt = rv_r;
    ridx_nxt = ridx_r;
    if (rv_r && !out_stall) begin
      if (drain_last) begin
        rv_nxt = 1'b0;
        ridx_nxt = '0;
      end else begin
        ridx_nxt = ridx_r + AW'(1);
      end
    end
    if (take && il_r) begin
      rv_nxt = 1'b1;
      ridx_nxt = '0;
    end
  end

  wkb_parser #(.DIMS(DIMS)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (ib_r),
    .last_byte (il_r),
    .ev        (ev)
  );

  wkb_bounds #(.DIMS(DIMS)) u_bounds (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev          (ev),
    .snap_take   (take),
    .snap_lo     (snap_lo),
    .snap_hi     (snap_hi),
    .snap_status (snap_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r   <= 1'b0;
      rv_r   <= 1'b0;
      ridx_r <= '0;
    end else begin
      iv_r   <= iv_nxt;
      rv_r   <= rv_nxt;
      ridx_r <= ridx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_r <= in_data_byte;
      il_r <= in_last_byte;
    end
    if (take && il_r) begin
      rst_r <= snap_status;
      for (int i = 0; i < DIMS; i++) begin
        rlo_r[i] <= snap_lo[i];
        rhi_r[i] <= snap_hi[i];
      end
    end
  end

  assign out_valid       = rv_r;
  assign out_dimension   = 2'(ridx_r);
  assign out_low_bound   = rlo_r[ridx_r];
  assign out_high_bound  = rhi_r[ridx_r];
  assign out_status      = rst_r;
  assign out_last_result = (32'(ridx_r) == DIMS - 1);

endmodule
